/* src/ipfe_pkg.sv */
package ipfe_pkg;

  // Number of recognised item identifiers; the kind code of an unknown item follows them.
  localparam int unsigned NUM_KINDS = 12;

  localparam logic [3:0] KIND_UTC     = 4'd2;
  localparam logic [3:0] KIND_UNKNOWN = 4'd12;

  // Element byte count value meaning the item takes no further bytes.
  localparam logic [2:0] FULL_MARK = 3'd7;

  // Reset value of the message identifier register.
  localparam logic [7:0] MESSAGE_ID_RESET = 8'd54;

  // Item identifiers, element sizes in bytes and element counts, by kind.
  localparam logic [15:0] ITEM_IDS [NUM_KINDS] = '{
    16'h1020, 16'h1060, 16'h1010, 16'h2030, 16'h2010, 16'h4020,
    16'h8020, 16'h5042, 16'h5022, 16'hC020, 16'hE020, 16'hD012
  };
  localparam logic [2:0] ELEM_SIZE [NUM_KINDS] = '{
    3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6, 3'd4, 3'd4, 3'd6
  };
  localparam logic [2:0] ELEM_COUNT [NUM_KINDS] = '{
    3'd1, 3'd1, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd3, 3'd1, 3'd3
  };

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_IDHI,
    PH_IDLO,
    PH_LEN,
    PH_PAY,
    PH_DONE
  } ipfe_phase_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } ipfe_in_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0]  field_kind;
    logic [1:0]  element_index;
    logic [47:0] field_value;
    logic        block_end;
  } ipfe_out_t;

  // Layout of the item currently being parsed.
  typedef struct packed {
    logic       known;
    logic [3:0] kind;
    logic [2:0] elem_size;
    logic [2:0] elem_count;
  } ipfe_item_info_t;

endpackage

/* src/ipfe_item_decode.sv */
module ipfe_item_decode (
  input  logic [15:0]               item_id,
  output ipfe_pkg::ipfe_item_info_t info
);
  import ipfe_pkg::*;

  // Match the identifier against the table of recognised items.
  always_comb begin
    info = '{known: 1'b0, kind: KIND_UNKNOWN, elem_size: 3'd0, elem_count: 3'd0};
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (item_id == ITEM_IDS[k]) begin
        info.known      = 1'b1;
        info.kind       = 4'(k);
        info.elem_size  = ELEM_SIZE[k];
        info.elem_count = ELEM_COUNT[k];
      end
    end
  end

endmodule

/* src/imu_data_packet_field_extractor.sv */
// A result appears on the output register in the cycle after the byte that completes it.
// Throughput: one byte per cycle; a byte is taken while a result still waits, as long
// as the output register is free or is being emptied in the same cycle.
// Reset (synchronous, rst_n low): the parser returns to idle, all parse state is cleared,
// the output holds no result and the message identifier returns to 54.
module imu_data_packet_field_extractor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ipfe_pkg::ipfe_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ipfe_pkg::ipfe_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_message_id
);
  import ipfe_pkg::*;

  logic            in_acc;
  ipfe_item_info_t info;

  logic [7:0]  message_id_r;
  ipfe_phase_t phase_r, phase_nxt;
  logic [1:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  block_rem_r, block_rem_nxt;
  logic [7:0]  item_rem_r, item_rem_nxt;
  logic [15:0] item_id_r, item_id_nxt;
  logic [47:0] shift_r, shift_nxt;
  logic [2:0]  ebc_r, ebc_nxt;
  logic [1:0]  ecnt_r, ecnt_nxt;

  logic        res_valid;
  ipfe_out_t   res;
  logic        out_valid_r, out_valid_nxt;
  ipfe_out_t   out_data_r, out_data_nxt;

  logic        last;
  logic        final_elem;
  logic [2:0]  ebc_inc;
  logic [47:0] shift_in;

  // Handshakes: the output register is free or being emptied this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ipfe_item_decode u_decode (
    .item_id (item_id_r),
    .info    (info)
  );

  // Helper values for the block and element bookkeeping.
  assign last       = (block_rem_r == 8'd1);
  assign ebc_inc    = ebc_r + 3'd1;
  assign shift_in   = {shift_r[39:0], in_data.data_byte};
  assign final_elem = (({1'b0, ecnt_r} + 3'd1) == info.elem_count);

  // Next parse state and result for the byte on the input.
  always_comb begin
    phase_nxt     = phase_r;
    byte_pos_nxt  = byte_pos_r;
    block_rem_nxt = block_rem_r;
    item_rem_nxt  = item_rem_r;
    item_id_nxt   = item_id_r;
    shift_nxt     = shift_r;
    ebc_nxt       = ebc_r;
    ecnt_nxt      = ecnt_r;
    res_valid     = 1'b0;
    res           = '{field_kind: KIND_UNKNOWN, element_index: 2'd0,
                      field_value: {32'd0, item_id_r}, block_end: last};

    if (in_data.first_byte) begin
      phase_nxt    = PH_HEAD;
      byte_pos_nxt = 2'd1;
    end else begin
      unique case (phase_r)
        PH_HEAD: begin
          if (byte_pos_r == 2'd1) begin
            byte_pos_nxt = 2'd2;
          end else if (byte_pos_r == 2'd2) begin
            if (in_data.data_byte != message_id_r) begin
              phase_nxt = PH_IDLE;
            end else begin
              byte_pos_nxt = 2'd3;
            end
          end else begin
            block_rem_nxt = in_data.data_byte;
            phase_nxt     = (in_data.data_byte == 8'd0) ? PH_DONE : PH_IDHI;
            byte_pos_nxt  = 2'd0;
          end
        end
        PH_IDHI: begin
          block_rem_nxt = block_rem_r - 8'd1;
          item_id_nxt   = {in_data.data_byte, 8'd0};
          phase_nxt     = last ? PH_DONE : PH_IDLO;
        end
        PH_IDLO: begin
          block_rem_nxt = block_rem_r - 8'd1;
          item_id_nxt   = {item_id_r[15:8], in_data.data_byte};
          phase_nxt     = last ? PH_DONE : PH_LEN;
        end
        PH_LEN: begin
          block_rem_nxt = block_rem_r - 8'd1;
          item_rem_nxt  = in_data.data_byte;
          shift_nxt     = '0;
          ecnt_nxt      = 2'd0;
          ebc_nxt       = info.known ? 3'd0 : FULL_MARK;
          // An unknown item gives one marker carrying its identifier.
          res_valid     = !info.known;
          if (last) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = (in_data.data_byte == 8'd0) ? PH_IDHI : PH_PAY;
          end
        end
        PH_PAY: begin
          block_rem_nxt = block_rem_r - 8'd1;
          item_rem_nxt  = item_rem_r - 8'd1;
          if (info.known && ebc_r != FULL_MARK) begin
            shift_nxt = shift_in;
            ebc_nxt   = ebc_inc;
            // An element is complete: emit it, the time item only at its last, and start any next one.
            if (ebc_inc == info.elem_size) begin
              res.field_kind    = info.kind;
              res.element_index = ecnt_r;
              res.field_value   = shift_in;
              if (info.kind == KIND_UTC) begin
                res_valid         = final_elem;
                res.element_index = 2'd0;
                res.field_value   = {24'd0, shift_in[31:8]};
              end else begin
                res_valid = 1'b1;
              end
              shift_nxt = '0;
              if (final_elem) begin
                ebc_nxt = FULL_MARK;
              end else begin
                ebc_nxt  = 3'd0;
                ecnt_nxt = ecnt_r + 2'd1;
              end
            end
          end
          if (last) begin
            phase_nxt = PH_DONE;
          end else if (item_rem_r == 8'd1) begin
            phase_nxt = PH_IDHI;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded on an accepted byte, emptied when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration, parse state and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_id_r <= MESSAGE_ID_RESET;
      phase_r      <= PH_IDLE;
      byte_pos_r   <= 2'd0;
      block_rem_r  <= 8'd0;
      item_rem_r   <= 8'd0;
      item_id_r    <= 16'd0;
      shift_r      <= 48'd0;
      ebc_r        <= 3'd0;
      ecnt_r       <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        message_id_r <= cfg_message_id;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        byte_pos_r  <= byte_pos_nxt;
        block_rem_r <= block_rem_nxt;
        item_rem_r  <= item_rem_nxt;
        item_id_r   <= item_id_nxt;
        shift_r     <= shift_nxt;
        ebc_r       <= ebc_nxt;
        ecnt_r      <= ecnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

/* test/tb_imu_data_packet_field_extractor.sv */
`timescale 1ns / 100ps

module tb_imu_data_packet_field_extractor;
  import ipfe_pkg::*;

  // Item layouts by kind: identifier, element size in bytes, element count.
  localparam int NUM_IDS = 12;
  localparam logic [15:0] ID_TABLE [NUM_IDS] = '{
    16'h1020, 16'h1060, 16'h1010, 16'h2030, 16'h2010, 16'h4020,
    16'h8020, 16'h5042, 16'h5022, 16'hC020, 16'hE020, 16'hD012
  };
  localparam int SIZE_OF [NUM_IDS] = '{2, 4, 4, 4, 4, 4, 4, 6, 6, 4, 4, 6};
  localparam int COUNT_OF [NUM_IDS] = '{1, 1, 3, 3, 4, 3, 3, 2, 1, 3, 1, 3};

  localparam logic [3:0] KIND_COUNTER = 4'd0;
  localparam logic [2:0] ELEM_DONE = 3'd7;
  localparam logic [7:0] MSG_ID_AT_RESET = 8'd54;

  // The longest quiet stretch of a correct run is a sender gap, a receiver stall
  // and the settling pause before a register write.
  localparam int QUIET_LIMIT = 1000;

  // How a row of the directed table is checked.
  localparam logic [1:0] ROW_PREDICT = 2'd0;
  localparam logic [1:0] ROW_QUIET   = 2'd1;
  localparam logic [1:0] ROW_FIXED   = 2'd2;

  localparam ipfe_out_t NO_FIELD = '0;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic [1:0] mode;
    ipfe_out_t  want;
  } script_row_t;

  // Directed bytes at the reset message identifier (0x36).
  localparam int SCRIPT_LEN = 27;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // Header with a 15 byte block.
    {8'hFA, 1'b1, ROW_QUIET, NO_FIELD},
    {8'hFF, 1'b0, ROW_QUIET, NO_FIELD},
    {8'h36, 1'b0, ROW_QUIET, NO_FIELD},
    {8'h0F, 1'b0, ROW_QUIET, NO_FIELD},
    // Counter item with all ones.
    {8'h10, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h20, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h02, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'hFF, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'hFF, 1'b0, ROW_FIXED, {KIND_COUNTER, 2'd0, 48'h00_FFFF, 1'b0}},
    // Unknown item 0xFFFF with one payload byte to be skipped.
    {8'hFF, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'hFF, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h01, 1'b0, ROW_FIXED, {KIND_UNKNOWN, 2'd0, 48'h00_FFFF, 1'b0}},
    {8'hAA, 1'b0, ROW_PREDICT, NO_FIELD},
    // Status item cut off by the block end: nothing comes out.
    {8'hE0, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h20, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h04, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h00, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h00, 1'b0, ROW_PREDICT, NO_FIELD},
    {8'h00, 1'b0, ROW_PREDICT, NO_FIELD},
    // Trailing byte after the block.
    {8'h55, 1'b0, ROW_QUIET, NO_FIELD},
    // Packet with the wrong message identifier.
    {8'hFA, 1'b1, ROW_QUIET, NO_FIELD},
    {8'h00, 1'b0, ROW_QUIET, NO_FIELD},
    {8'h00, 1'b0, ROW_QUIET, NO_FIELD},
    // Packet with an empty block.
    {8'h00, 1'b1, ROW_QUIET, NO_FIELD},
    {8'hFF, 1'b0, ROW_QUIET, NO_FIELD},
    {8'h36, 1'b0, ROW_QUIET, NO_FIELD},
    {8'h00, 1'b0, ROW_QUIET, NO_FIELD}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  ipfe_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ipfe_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_message_id = MSG_ID_AT_RESET;

  // Predictor state.
  logic [7:0]   msg_id_model = MSG_ID_AT_RESET;
  ipfe_phase_t  phase_model = PH_IDLE;
  logic [1:0]   hdr_pos = '0;
  logic [7:0]   blk_left = '0;
  logic [7:0]   item_left = '0;
  logic [15:0]  item_id = '0;
  logic [47:0]  elem_acc = '0;
  logic [2:0]   elem_bytes = '0;
  logic [1:0]   elem_idx = '0;

  ipfe_out_t    expected_fields [$];
  ipfe_out_t    want_field;
  int unsigned  bytes_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_left = 0;
  logic         idle_on = 1'b1;
  logic         calm = 1'b0;

  imu_data_packet_field_extractor u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_message_id (cfg_message_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0] kind_for_id(input logic [15:0] id);
    logic [3:0] k;
    k = KIND_UNKNOWN;
    for (int i = 0; i < NUM_IDS; i++) begin
      if (ID_TABLE[i] == id) begin
        k = 4'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Advances the parser by one byte and gives the field that byte completes, if any.
  task automatic extract_field(input ipfe_in_t x, output logic got, output ipfe_out_t r);
    logic       last;
    logic       fin;
    logic [3:0] k;
    logic [7:0] b;
    got = 1'b0;
    r = '0;
    b = x.data_byte;
    if (x.first_byte) begin
      phase_model = PH_HEAD;
      hdr_pos = 2'd1;
    end else if (phase_model == PH_HEAD) begin
      if (hdr_pos == 2'd1) begin
        hdr_pos = 2'd2;
      end else if (hdr_pos == 2'd2) begin
        if (b != msg_id_model) begin
          phase_model = PH_IDLE;
        end else begin
          hdr_pos = 2'd3;
        end
      end else begin
        blk_left = b;
        phase_model = (b == 8'd0) ? PH_DONE : PH_IDHI;
        hdr_pos = 2'd0;
      end
    end else if (phase_model >= PH_IDHI && phase_model <= PH_PAY) begin
      last = (blk_left == 8'd1);
      blk_left = blk_left - 8'd1;
      case (phase_model)
        PH_IDHI: begin
          item_id = {b, 8'd0};
          phase_model = PH_IDLO;
        end
        PH_IDLO: begin
          item_id = {item_id[15:8], b};
          phase_model = PH_LEN;
        end
        PH_LEN: begin
          item_left = b;
          elem_acc = '0;
          elem_idx = '0;
          k = kind_for_id(item_id);
          elem_bytes = (k == KIND_UNKNOWN) ? ELEM_DONE : 3'd0;
          if (k == KIND_UNKNOWN) begin
            got = 1'b1;
            r.field_kind = KIND_UNKNOWN;
            r.element_index = 2'd0;
            r.field_value = {32'd0, item_id};
            r.block_end = last;
          end
          phase_model = (b == 8'd0) ? PH_IDHI : PH_PAY;
        end
        default: begin
          item_left = item_left - 8'd1;
          k = kind_for_id(item_id);
          if (k != KIND_UNKNOWN && elem_bytes != ELEM_DONE) begin
            elem_acc = {elem_acc[39:0], b};
            elem_bytes = elem_bytes + 3'd1;
            if (int'(elem_bytes) == SIZE_OF[k]) begin
              fin = (int'(elem_idx) + 1 == COUNT_OF[k]);
              // The time item gives three bytes of its last element packed, once it is whole.
              if (k != KIND_UTC || fin) begin
                got = 1'b1;
                r.field_kind = k;
                r.element_index = (k == KIND_UTC) ? 2'd0 : elem_idx;
                r.field_value = (k == KIND_UTC) ? {24'd0, elem_acc[31:8]} : elem_acc;
                r.block_end = last;
              end
              elem_acc = '0;
              if (fin) begin
                elem_bytes = ELEM_DONE;
              end else begin
                elem_bytes = 3'd0;
                elem_idx = elem_idx + 2'd1;
              end
            end
          end
          if (item_left == 8'd0) begin
            phase_model = PH_IDHI;
          end
        end
      endcase
      if (last) begin
        phase_model = PH_DONE;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    error_count++;
  endtask

  // Offers one byte, waits for the transaction and records what it should produce.
  task automatic send_byte(input ipfe_in_t x, input logic [1:0] mode,
                           input ipfe_out_t fixed_want);
    logic      got;
    ipfe_out_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    extract_field(x, got, r);
    if (mode == ROW_FIXED) begin
      expected_fields.push_back(fixed_want);
    end else if (mode == ROW_PREDICT && got) begin
      expected_fields.push_back(r);
    end
    bytes_sent++;
  endtask

  // Register writes happen only once the parser has drained.
  task automatic set_message_id(input logic [7:0] id);
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_message_id <= id;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    msg_id_model = id;
  endtask

  // Builds one random packet: mostly well formed, sometimes noise, a wrong
  // identifier, an empty block or a packet cut short by the next preamble.
  task automatic send_packet();
    logic [7:0]  body [$];
    ipfe_in_t    pkt [$];
    logic [15:0] id;
    int          sel;
    int          k;
    int          nominal;
    int          len;
    int          blen;
    int          cut;
    sel = $urandom_range(0, 19);
    idle_on = !calm && ($urandom_range(0, 3) != 0);
    if (sel == 17) begin
      repeat ($urandom_range(1, 8)) pkt.push_back({rand_byte(), $urandom_range(0, 7) == 0});
    end else begin
      pkt.push_back({rand_byte(), 1'b1});
      pkt.push_back({rand_byte(), 1'b0});
      if (sel == 15 || sel == 16) begin
        pkt.push_back({msg_id_model ^ 8'($urandom_range(1, 255)), 1'b0});
        repeat ($urandom_range(0, 6)) pkt.push_back({rand_byte(), 1'b0});
      end else if (sel == 18) begin
        pkt.push_back({msg_id_model, 1'b0});
        pkt.push_back({8'd0, 1'b0});
        repeat ($urandom_range(0, 3)) pkt.push_back({rand_byte(), 1'b0});
      end else begin
        pkt.push_back({msg_id_model, 1'b0});
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, 12);
          if (k < NUM_IDS) begin
            id = ID_TABLE[k];
            nominal = SIZE_OF[k] * COUNT_OF[k];
          end else begin
            do id = 16'($urandom_range(0, 65535)); while (kind_for_id(id) != KIND_UNKNOWN);
            nominal = $urandom_range(0, 6);
          end
          case ($urandom_range(0, 9))
            7: begin
              len = $urandom_range(0, nominal);
            end
            8: begin
              len = nominal + $urandom_range(1, 4);
            end
            9: begin
              len = 0;
            end
            default: begin
              len = nominal;
            end
          endcase
          body.push_back(id[15:8]);
          body.push_back(id[7:0]);
          body.push_back(8'(len));
          repeat (len) body.push_back(rand_byte());
        end
        // Now and then the block length cuts into the items.
        blen = body.size();
        if ($urandom_range(0, 5) == 0) begin
          blen = $urandom_range(1, body.size());
        end
        pkt.push_back({8'(blen), 1'b0});
        foreach (body[i]) pkt.push_back({body[i], 1'b0});
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) pkt.push_back({rand_byte(), 1'b0});
        end
        if (sel == 19) begin
          cut = $urandom_range(1, pkt.size() - 1);
          pkt = pkt[0:cut - 1];
        end
      end
    end
    foreach (pkt[i]) send_byte(pkt[i], ROW_PREDICT, NO_FIELD);
  endtask

  // Receiver: stalls at random while idling is on.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("result with nothing expected", out_data.field_value, '0);
      end else begin
        want_field = expected_fields.pop_front();
        if (out_data.field_kind != want_field.field_kind) begin
          report_mismatch("field_kind", 48'(out_data.field_kind),
                          48'(want_field.field_kind));
        end
        if (out_data.element_index != want_field.element_index) begin
          report_mismatch("element_index", 48'(out_data.element_index),
                          48'(want_field.element_index));
        end
        if (out_data.field_value != want_field.field_value) begin
          report_mismatch("field_value", out_data.field_value, want_field.field_value);
        end
        if (out_data.block_end != want_field.block_end) begin
          report_mismatch("block_end", 48'(out_data.block_end),
                          48'(want_field.block_end));
        end
      end
      results_seen++;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned byte_goal;
    logic [7:0]  next_id;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[i]) begin
      send_byte({SCRIPT[i].data, SCRIPT[i].first}, SCRIPT[i].mode, SCRIPT[i].want);
    end

    // Random phases under different identifiers; the last one runs without idling.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          next_id = 8'hFF;
        end
        1: begin
          next_id = 8'h00;
        end
        2: begin
          next_id = 8'($urandom_range(1, 254));
        end
        default: begin
          next_id = MSG_ID_AT_RESET;
        end
      endcase
      calm = (p == 3);
      set_message_id(next_id);
      byte_goal = bytes_sent + 400;
      while (bytes_sent < byte_goal) send_packet();
    end

    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/ipfe_pkg.sv
src/ipfe_item_decode.sv
src/imu_data_packet_field_extractor.sv
test/tb_imu_data_packet_field_extractor.sv
